// ===== rtl/pdws_pkg.sv =====
// Package for the PWM divider and wrap selection block.
// Holds shared constants and the sideband types carried through the divider chains.
// No dependencies.
`default_nettype none
package pdws_pkg;

  localparam int FREQ_FRAC_BITS = 8;
  localparam int WRAP_MAX = 65536;
  localparam int WRAP_MIN = 100;
  localparam int DIV_ONE = 16;
  localparam int DIV_MAX = 4095;
  localparam logic [28:0] CLOCK_RESET = 29'd125000000;

  // Width of the scaled clock count clock_hz << FREQ_FRAC_BITS.
  localparam int N_W = 29 + FREQ_FRAC_BITS;

  // Sideband through the divider search chain.
  typedef struct packed {
    logic [31:0]    t;
    logic [N_W-1:0] n;
    logic           zero;
    logic           fits;
  } side1_t;

  // Sideband through the wrap chain.
  typedef struct packed {
    logic [N_W-1:0] n;
    logic [11:0]    div;
    logic           zero;
    logic           flag;
    logic           ovf;
  } side2_t;

  // Sideband through the realized frequency chain.
  typedef struct packed {
    logic [11:0] div;
    logic [16:0] wrap;
    logic        flag;
    logic        ovf;
  } side3_t;

endpackage
`default_nettype wire

// ===== rtl/pdws_div_cell.sv =====
// One restoring division step: compares the remainder with the shifted divisor.
// Registered cell of a divider chain; no package dependencies.
`default_nettype none
module pdws_div_cell #(
  parameter int W  = 62,
  parameter int QW = 17,
  parameter int SW = 8,
  parameter int K  = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          valid_in,
  input  wire logic [W-1:0]  rem_in,
  input  wire logic [W-1:0]  dvs_in,
  input  wire logic [QW-1:0] quo_in,
  input  wire logic [SW-1:0] side_in,
  output logic               valid,
  output logic [W-1:0]       rem,
  output logic [W-1:0]       dvs,
  output logic [QW-1:0]      quo,
  output logic [SW-1:0]      side
);

  logic [W-1:0] shifted;
  logic         ge;

  // Trial subtraction of the divisor weighted by this cell's quotient bit.
  always_comb begin
    shifted = dvs_in << K;
    ge      = rem_in >= shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? (rem_in - shifted) : rem_in;
      dvs  <= dvs_in;
      quo  <= {quo_in[QW-2:0], ge};
      side <= side_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pdws_div_chain.sv =====
// Pipelined restoring divider: a row of QW cells, one quotient bit per cell.
// Depends on pdws_div_cell. Requires the dividend below divisor << QW.
`default_nettype none
module pdws_div_chain #(
  parameter int W  = 62,
  parameter int QW = 17,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          valid_in,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [W-1:0]  divisor,
  input  wire logic [SW-1:0] side_in,
  output logic               valid,
  output logic [QW-1:0]      quotient,
  output logic [SW-1:0]      side
);

  logic          v_w [QW+1];
  logic [W-1:0]  r_w [QW+1];
  logic [W-1:0]  d_w [QW+1];
  logic [QW-1:0] q_w [QW+1];
  logic [SW-1:0] s_w [QW+1];

  assign v_w[0] = valid_in;
  assign r_w[0] = dividend;
  assign d_w[0] = divisor;
  assign q_w[0] = '0;
  assign s_w[0] = side_in;

  // The most significant quotient bit is resolved first.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    pdws_div_cell #(
      .W (W),
      .QW(QW),
      .SW(SW),
      .K (QW - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_in(v_w[i]),
      .rem_in  (r_w[i]),
      .dvs_in  (d_w[i]),
      .quo_in  (q_w[i]),
      .side_in (s_w[i]),
      .valid   (v_w[i+1]),
      .rem     (r_w[i+1]),
      .dvs     (d_w[i+1]),
      .quo     (q_w[i+1]),
      .side    (s_w[i+1])
    );
  end

  assign valid    = v_w[QW];
  assign quotient = q_w[QW];
  assign side     = s_w[QW];

endmodule
`default_nettype wire

// ===== rtl/pwm_divider_wrap_select_unit.sv =====
// Top level of the PWM divider and wrap selection block.
// Depends on pdws_pkg and pdws_div_chain.
//
// Usage: write clock_hz through cfg_write_en / cfg_write_data while idle; it
// resets to 125 MHz. Each target_frequency transfer on the input channel
// (in_valid / in_ready) produces exactly one result transfer on the output
// channel (out_valid / out_ready) with divider, wrap, realized frequency and
// the out_of_range flag.
// The path from input transfer to output valid runs through nine single
// registers and three pipelined restoring divider chains of 25, 17 and 32
// cells, one quotient bit per cell. One item per cycle when not stalled.
// The whole pipeline advances on one enable, high when the output register
// is empty or being taken; while the receiver stalls with a result waiting,
// every stage holds and in_ready is low. Reset clears all valid bits and
// loads the clock register with its default.
`default_nettype none
module pwm_divider_wrap_select_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [28:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] target_frequency,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      divider_sixteenths,
  output logic [16:0]      wrap_count,
  output logic [31:0]      realized_frequency,
  output logic             out_of_range
);

  localparam int NW = pdws_pkg::N_W;
  localparam int W1 = 57;
  localparam int W2 = 62;
  localparam int W3 = 62;

  logic en;
  logic [28:0] clock_hz;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Clock configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= pdws_pkg::CLOCK_RESET;
    end else if (cfg_write_en) begin
      clock_hz <= cfg_write_data;
    end
  end

  // Input register: target and scaled clock count.
  logic          s0_valid;
  logic [31:0]   s0_t;
  logic [NW-1:0] s0_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_t <= target_frequency;
      s0_n <= NW'(clock_hz) << pdws_pkg::FREQ_FRAC_BITS;
    end
  end

  // Branch decision and the operand of the divider search.
  logic             s1_valid;
  pdws_pkg::side1_t s1_side;
  logic [24:0]      s1_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.t    <= s0_t;
      s1_side.n    <= s0_n;
      s1_side.zero <= s0_t == 32'd0;
      s1_side.fits <= 49'(s0_n) <= (49'(s0_t) << 16);
      s1_m         <= 25'((s0_n - NW'(1)) >> 12);
    end
  end

  // Divider search: floor((n - 1) / 4096 / t), the ceiling minus one.
  logic                         c1_valid;
  logic [24:0]                  c1_q;
  logic [$bits(pdws_pkg::side1_t)-1:0] c1_side_raw;
  pdws_pkg::side1_t             c1_side;

  pdws_div_chain #(
    .W (W1),
    .QW(25),
    .SW($bits(pdws_pkg::side1_t))
  ) u_chain_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid_in(s1_valid),
    .dividend(W1'(s1_m)),
    .divisor (W1'(s1_side.t)),
    .side_in (s1_side),
    .valid   (c1_valid),
    .quotient(c1_q),
    .side    (c1_side_raw)
  );

  assign c1_side = pdws_pkg::side1_t'(c1_side_raw);

  // Divider selection with saturation.
  logic          sb_valid;
  logic [31:0]   sb_t;
  logic [NW-1:0] sb_n;
  logic          sb_zero;
  logic          sb_fits;
  logic [11:0]   sb_div;
  logic          sb_flag;
  logic          c1_sat;

  assign c1_sat = c1_q >= 25'(pdws_pkg::DIV_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else if (en) begin
      sb_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_t    <= c1_side.t;
      sb_n    <= c1_side.n;
      sb_zero <= c1_side.zero;
      sb_fits <= c1_side.fits;
      if (c1_side.zero || (!c1_side.fits && c1_sat)) begin
        sb_div <= 12'(pdws_pkg::DIV_MAX);
      end else if (c1_side.fits) begin
        sb_div <= 12'(pdws_pkg::DIV_ONE);
      end else begin
        sb_div <= 12'(c1_q) + 12'd1;
      end
      sb_flag <= c1_side.zero || (!c1_side.fits && c1_sat);
    end
  end

  // Divisor of the wrap quotient: div * t.
  logic          sc_valid;
  logic [31:0]   sc_t;
  logic [NW-1:0] sc_n;
  logic          sc_zero;
  logic          sc_fits;
  logic [11:0]   sc_div;
  logic          sc_flag;
  logic [43:0]   sc_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (en) begin
      sc_valid <= sb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_t    <= sb_t;
      sc_n    <= sb_n;
      sc_zero <= sb_zero;
      sc_fits <= sb_fits;
      sc_div  <= sb_div;
      sc_flag <= sb_flag;
      sc_prod <= 44'(sb_div) * 44'(sb_t);
    end
  end

  // Rounded wrap operands and the overflow check for a 17-bit quotient.
  logic [44:0]      sd_x_c;
  logic [44:0]      sd_y_c;
  logic             sd_valid;
  logic [W2-1:0]    sd_x;
  logic [W2-1:0]    sd_y;
  pdws_pkg::side2_t sd_side;

  always_comb begin
    if (sc_fits) begin
      sd_x_c = (45'(sc_n) << 1) + 45'(sc_t);
      sd_y_c = 45'(sc_t) << 1;
    end else begin
      sd_x_c = (45'(sc_n) << 5) + 45'(sc_prod);
      sd_y_c = 45'(sc_prod) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid <= 1'b0;
    end else if (en) begin
      sd_valid <= sc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_x         <= W2'(sd_x_c);
      sd_y         <= W2'(sd_y_c);
      sd_side.n    <= sc_n;
      sd_side.div  <= sc_div;
      sd_side.zero <= sc_zero;
      sd_side.flag <= sc_flag;
      sd_side.ovf  <= W2'(sd_x_c) >= (W2'(sd_y_c) << 17);
    end
  end

  // Wrap quotient.
  logic                                c2_valid;
  logic [16:0]                         c2_q;
  logic [$bits(pdws_pkg::side2_t)-1:0] c2_side_raw;
  pdws_pkg::side2_t                    c2_side;

  pdws_div_chain #(
    .W (W2),
    .QW(17),
    .SW($bits(pdws_pkg::side2_t))
  ) u_chain_wrap (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid_in(sd_valid),
    .dividend(sd_x),
    .divisor (sd_y),
    .side_in (sd_side),
    .valid   (c2_valid),
    .quotient(c2_q),
    .side    (c2_side_raw)
  );

  assign c2_side = pdws_pkg::side2_t'(c2_side_raw);

  // Wrap clamping to its allowed range.
  logic          se_valid;
  logic [NW-1:0] se_n;
  logic [11:0]   se_div;
  logic [16:0]   se_wrap;
  logic          se_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      se_valid <= 1'b0;
    end else if (en) begin
      se_valid <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se_n    <= c2_side.n;
      se_div  <= c2_side.div;
      se_flag <= c2_side.flag;
      if (c2_side.zero || c2_side.ovf || c2_q > 17'(pdws_pkg::WRAP_MAX)) begin
        se_wrap <= 17'(pdws_pkg::WRAP_MAX);
      end else if (c2_q < 17'(pdws_pkg::WRAP_MIN)) begin
        se_wrap <= 17'(pdws_pkg::WRAP_MIN);
      end else begin
        se_wrap <= c2_q;
      end
    end
  end

  // Counter period in undivided sixteenths: div * wrap.
  logic          sf_valid;
  logic [NW-1:0] sf_n;
  logic [11:0]   sf_div;
  logic [16:0]   sf_wrap;
  logic          sf_flag;
  logic [28:0]   sf_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_valid <= 1'b0;
    end else if (en) begin
      sf_valid <= se_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf_n    <= se_n;
      sf_div  <= se_div;
      sf_wrap <= se_wrap;
      sf_flag <= se_flag;
      sf_den  <= 29'(se_div) * 29'(se_wrap);
    end
  end

  // Realized frequency operands and the saturation check.
  logic [42:0]      sg_x_c;
  logic [29:0]      sg_y_c;
  logic             sg_valid;
  logic [W3-1:0]    sg_x;
  logic [W3-1:0]    sg_y;
  pdws_pkg::side3_t sg_side;

  assign sg_x_c = (43'(sf_n) << 5) + 43'(sf_den);
  assign sg_y_c = 30'(sf_den) << 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sg_valid <= 1'b0;
    end else if (en) begin
      sg_valid <= sf_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_x         <= W3'(sg_x_c);
      sg_y         <= W3'(sg_y_c);
      sg_side.div  <= sf_div;
      sg_side.wrap <= sf_wrap;
      sg_side.flag <= sf_flag;
      sg_side.ovf  <= W3'(sg_x_c) >= (W3'(sg_y_c) << 32);
    end
  end

  // Realized frequency quotient.
  logic                                c3_valid;
  logic [31:0]                         c3_q;
  logic [$bits(pdws_pkg::side3_t)-1:0] c3_side_raw;
  pdws_pkg::side3_t                    c3_side;

  pdws_div_chain #(
    .W (W3),
    .QW(32),
    .SW($bits(pdws_pkg::side3_t))
  ) u_chain_freq (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid_in(sg_valid),
    .dividend(sg_x),
    .divisor (sg_y),
    .side_in (sg_side),
    .valid   (c3_valid),
    .quotient(c3_q),
    .side    (c3_side_raw)
  );

  assign c3_side = pdws_pkg::side3_t'(c3_side_raw);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      divider_sixteenths <= c3_side.div;
      wrap_count         <= c3_side.wrap;
      realized_frequency <= c3_side.ovf ? 32'hFFFF_FFFF : c3_q;
      out_of_range       <= c3_side.flag;
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the PWM divider and wrap selection unit.
// Depends on pdws_pkg and pwm_divider_wrap_select_unit; predicts each result in place.
`default_nettype none
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [28:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] target_frequency = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] divider_sixteenths;
  logic [16:0] wrap_count;
  logic [31:0] realized_frequency;
  logic        out_of_range;

  typedef struct packed {
    logic [11:0] div;
    logic [16:0] wrap;
    logic [31:0] real_freq;
    logic        flag;
  } pwm_setting_t;

  typedef struct {
    logic [28:0] clock;
    logic [31:0] target;
    logic        known;
    pwm_setting_t want;
  } row_t;

  pwm_setting_t pending_settings[$];
  logic [28:0]  clock_setting = pdws_pkg::CLOCK_RESET;
  int           mismatches = 0;
  int           checked = 0;
  int           calm = 0;
  bit           sink_calm = 1'b0;
  row_t         rows[$];

  pwm_divider_wrap_select_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready), .target_frequency(target_frequency),
    .out_valid(out_valid), .out_ready(out_ready),
    .divider_sixteenths(divider_sixteenths), .wrap_count(wrap_count),
    .realized_frequency(realized_frequency), .out_of_range(out_of_range)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] rdiv(logic [63:0] a, logic [63:0] b);
    return (2 * a + b) / (2 * b);
  endfunction

  // Divider, wrap and achieved rate for one target at the given clock.
  function automatic pwm_setting_t pwm_setting(logic [28:0] clock, logic [31:0] target);
    logic [63:0] n, t, dv, w, r, d;
    pwm_setting_t s;
    n = 64'(clock) << pdws_pkg::FREQ_FRAC_BITS;
    t = 64'(target);
    dv = 64'(pdws_pkg::DIV_ONE);
    s.flag = 1'b0;
    if (t == 0) begin
      dv = 64'(pdws_pkg::DIV_MAX);
      w = 64'(pdws_pkg::WRAP_MAX);
      s.flag = 1'b1;
    end else if (n <= 64'(pdws_pkg::WRAP_MAX) * t) begin
      w = rdiv(n, t);
    end else begin
      d = 64'(pdws_pkg::WRAP_MAX) * t;
      dv = (64'(pdws_pkg::DIV_ONE) * n + d - 64'd1) / d;
      if (dv > 64'(pdws_pkg::DIV_MAX)) begin
        dv = 64'(pdws_pkg::DIV_MAX);
        s.flag = 1'b1;
      end
      w = rdiv(64'(pdws_pkg::DIV_ONE) * n, dv * t);
    end
    if (w > 64'(pdws_pkg::WRAP_MAX)) w = 64'(pdws_pkg::WRAP_MAX);
    if (w < 64'(pdws_pkg::WRAP_MIN)) w = 64'(pdws_pkg::WRAP_MIN);
    r = rdiv(64'(pdws_pkg::DIV_ONE) * n, dv * w);
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    s.div = dv[11:0];
    s.wrap = w[16:0];
    s.real_freq = r[31:0];
    return s;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %0s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Receiver: random stalls, checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    pwm_setting_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_settings.size() == 0) begin
          report("unexpected result", 64'd0, 64'd0);
        end else begin
          e = pending_settings.pop_front();
          checked++;
          if (divider_sixteenths !== e.div)
            report("divider", 64'(divider_sixteenths), 64'(e.div));
          if (wrap_count !== e.wrap) report("wrap", 64'(wrap_count), 64'(e.wrap));
          if (realized_frequency !== e.real_freq)
            report("realized", 64'(realized_frequency), 64'(e.real_freq));
          if (out_of_range !== e.flag) report("flag", 64'(out_of_range), 64'(e.flag));
        end
      end
      out_ready <= sink_calm || ($urandom_range(99) >= 23);
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_clock(logic [28:0] v);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    clock_setting = v;
  endtask

  // Offer one target, with a random gap before it unless in a calm stretch.
  task automatic send(logic [31:0] t);
    while (calm == 0 && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    target_frequency <= t;
    pending_settings.insert(pending_settings.size(), pwm_setting(clock_setting, t));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] random_target();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(255);
      2: return $urandom_range(1 << 20);
      3: return $urandom_range(1 << 28);
      default: return 32'hFFFF_FFFF - $urandom_range(1 << 16);
    endcase
  endfunction

  function automatic void add_row(logic [28:0] c, logic [31:0] t, logic k, pwm_setting_t w);
    row_t r;
    r.clock = c; r.target = t; r.known = k; r.want = w;
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    row_t r;
    logic [28:0] clocks[5];
    // Directed table: typed expectations for the obvious rows.
    add_row(pdws_pkg::CLOCK_RESET, 32'd0, 1'b1, '{12'd4095, 17'd65536, 32'd1908, 1'b1});
    add_row(pdws_pkg::CLOCK_RESET, 32'hFFFF_FFFF, 1'b1,
            '{12'd16, 17'd100, 32'd320000000, 1'b0});
    add_row(pdws_pkg::CLOCK_RESET, 32'd1, 1'b1, '{12'd4095, 17'd65536, 32'd1908, 1'b1});
    add_row(pdws_pkg::CLOCK_RESET, 32'd256000, 1'b0, '0);
    add_row(pdws_pkg::CLOCK_RESET, 32'd488281, 1'b0, '0);
    add_row(pdws_pkg::CLOCK_RESET, 32'd488282, 1'b0, '0);
    add_row(pdws_pkg::CLOCK_RESET, 32'd7630, 1'b0, '0);
    add_row(pdws_pkg::CLOCK_RESET, 32'd7700, 1'b0, '0);
    add_row(pdws_pkg::CLOCK_RESET, 32'h5555_5555, 1'b0, '0);
    add_row(pdws_pkg::CLOCK_RESET, 32'hAAAA_AAAA, 1'b0, '0);
    add_row(29'd0, 32'd1000, 1'b1, '{12'd16, 17'd100, 32'd0, 1'b0});
    add_row(29'd0, 32'd0, 1'b1, '{12'd4095, 17'd65536, 32'd0, 1'b1});
    add_row(29'h1FFF_FFFF, 32'd1, 1'b0, '0);
    add_row(29'h1FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(29'h1FFF_FFFF, 32'd2560, 1'b0, '0);
    add_row(29'd1000000, 32'd256, 1'b0, '0);
    add_row(29'd1000000, 32'd3907, 1'b0, '0);
    add_row(29'd500000000, 32'd5000, 1'b0, '0);
    add_row(29'd500000000, 32'd12345678, 1'b0, '0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      r = rows[i];
      if (r.clock != clock_setting) begin
        wait_drained();
        write_clock(r.clock);
      end
      send(r.target);
      if (r.known) pending_settings[$] = r.want;
    end
    // Random part in phases with several clock settings, the extremes included.
    clocks = '{29'd1000000, 29'd500000000, pdws_pkg::CLOCK_RESET, 29'h1FFF_FFFF, 29'd0};
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_clock(p < 5 ? clocks[p] : 29'($urandom));
      for (int i = 0; i < 75; i++) begin
        if (p == 2 && i == 0) begin
          calm = 1; sink_calm = 1'b1;
        end
        if (p == 2 && i == 60) begin
          calm = 0; sink_calm = 1'b0;
        end
        send(random_target());
      end
    end
    wait_drained();
    $display("checked %0d results over %0d directed rows and six clock phases",
             checked, rows.size());
    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench failed");
    $finish;
  end
endmodule
`default_nettype wire
